/* hw/rtl/readers_writers_admission_arbiter_core_defines.svh */
// ----------------------------------------------------------------------------
// Readers-writers admission arbiter: assertion macros
// Shared assertion forms for the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef READERS_WRITERS_ADMISSION_ARBITER_CORE_DEFINES_SVH
`define READERS_WRITERS_ADMISSION_ARBITER_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset
`define RWAAC_CHECK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rwa_checker: property failed");

// Property checked on every clock edge, reset included
`define RWAAC_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rwa_checker: property failed across reset");

`endif

/* hw/rtl/rwa_pkg.sv */
// ----------------------------------------------------------------------------
// rwa_pkg
// Types, sizes and codes shared by the admission arbiter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwa_pkg;

  // Person identifier width
  localparam int ID_W = 8;

  // Queue sizes
  localparam int RQ_DEPTH          = 16;
  localparam int WQ_DEPTH          = 16;
  localparam int OCC_DEPTH         = 32;
  localparam int MAX_READER_ADMITS = 16;
  localparam int CMDQ_DEPTH        = 2;

  // Derived widths
  localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);
  localparam int WQ_PTR_W   = $clog2(WQ_DEPTH);
  localparam int WQ_CNT_W   = $clog2(WQ_DEPTH + 1);
  localparam int OCC_PTR_W  = $clog2(OCC_DEPTH);
  localparam int OCC_CNT_W  = $clog2(OCC_DEPTH + 1);
  localparam int OCC_W      = ID_W + 1;
  localparam int ADM_W      = $clog2(MAX_READER_ADMITS + 1);
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Request type codes on the input word
  localparam logic [1:0] REQ_READER = 2'd0;
  localparam logic [1:0] REQ_WRITER = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_READER,
    OP_WRITER,
    OP_TICK,
    OP_NOP
  } rwa_op_t;

  // Command handed from front to back
  typedef struct packed {
    rwa_op_t         op;
    logic [ID_W-1:0] id;
  } rwa_cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_DROP  = 2'd2
  } rwa_kind_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_FETCH,
    ST_EVENT,
    ST_SETTLE,
    ST_ADMIT
  } rwa_state_t;

endpackage

/* hw/rtl/rwa_ram.sv */
// ----------------------------------------------------------------------------
// rwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port (old data on same-address write)
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* hw/rtl/rwa_front.sv */
// ----------------------------------------------------------------------------
// rwa_front
// Accepts input words, classifies the request and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwa_front import rwa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_req_type,
  input  logic [ID_W-1:0] in_requester_id,
  output logic            cmd_valid,
  output rwa_cmd_t        cmd,
  input  logic            cmd_pop
);

  rwa_cmd_t              q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  rwa_cmd_t              cls;
  logic                  accept;
  logic                  pop;

  // Classify the request
  always_comb begin
    cls.id = in_requester_id;
    unique case (in_req_type)
      REQ_READER: cls.op = OP_READER;
      REQ_WRITER: cls.op = OP_WRITER;
      REQ_TICK:   cls.op = OP_TICK;
      default:    cls.op = OP_NOP;
    endcase
  end

  // Handshake
  assign in_stall  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                             : CMDQ_PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                             : CMDQ_PTR_W'(rd_ptr_r + 1'b1);
    end
    if (accept && !pop) begin
      cnt_nxt = CMDQ_CNT_W'(cnt_r + 1'b1);
    end else if (pop && !accept) begin
      cnt_nxt = CMDQ_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* hw/rtl/rwa_back.sv */
// ----------------------------------------------------------------------------
// rwa_back
// Carries out queued commands: wait queues, occupant queue, admissions
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwa_back import rwa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  input  rwa_cmd_t        cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_event_kind,
  output logic [ID_W-1:0] out_person_id,
  output logic            out_person_is_writer,
  output logic            out_last
);

  rwa_state_t state_r, state_nxt;
  rwa_cmd_t   cmd_r;

  logic [RQ_PTR_W-1:0]  rq_head_r, rq_head_nxt, rq_tail_r;
  logic [RQ_CNT_W-1:0]  rq_cnt_r;
  logic [WQ_PTR_W-1:0]  wq_head_r, wq_head_nxt, wq_tail_r;
  logic [WQ_CNT_W-1:0]  wq_cnt_r;
  logic [OCC_PTR_W-1:0] occ_head_r, occ_head_nxt, occ_tail_r;
  logic [OCC_CNT_W-1:0] occ_cnt_r;
  logic                 wi_r;
  logic [ADM_W-1:0]     adm_r;

  logic [ID_W-1:0]  rq_rd;
  logic [ID_W-1:0]  wq_rd;
  logic [OCC_W-1:0] occ_rd;

  // Action strobes
  logic             rq_push, rq_pop, wq_push, wq_pop, occ_push, occ_pop;
  logic [OCC_W-1:0] occ_push_data;
  logic             wi_set, wi_clr, adm_clr, adm_inc;
  rwa_kind_t        emit_kind;
  logic [ID_W-1:0]  emit_id;
  logic             emit_wr, emit_last;

  // Result register
  logic             out_valid_r;
  rwa_kind_t        out_kind_r;
  logic [ID_W-1:0]  out_id_r;
  logic             out_wr_r, out_last_r;

  // Conditions
  logic                 rq_full, wq_full, ev_tick, ev_emit, wi_post, ev_follow;
  logic [OCC_CNT_W-1:0] occ_post;
  logic                 adm_rd, adm_wr, adm_rd_last;
  logic                 emit_req, out_free, go;

  assign rq_full = (rq_cnt_r == RQ_CNT_W'(RQ_DEPTH));
  assign wq_full = (wq_cnt_r == WQ_CNT_W'(WQ_DEPTH));
  assign ev_tick = (cmd_r.op == OP_TICK) && (occ_cnt_r != '0);
  assign ev_emit = ((cmd_r.op == OP_READER) && rq_full) ||
                   ((cmd_r.op == OP_WRITER) && wq_full) || ev_tick;

  // State just after the event, to tell if admissions follow it
  assign wi_post   = wi_r && !(ev_tick && occ_rd[OCC_W-1]);
  assign occ_post  = ev_tick ? OCC_CNT_W'(occ_cnt_r - 1'b1) : occ_cnt_r;
  assign ev_follow = !wi_post &&
                     (((rq_cnt_r != '0) && (occ_post < OCC_CNT_W'(OCC_DEPTH))) ||
                      ((rq_cnt_r == '0) && (occ_post == '0) && (wq_cnt_r != '0)));

  // Admission conditions
  assign adm_rd = !wi_r && (rq_cnt_r != '0) && (occ_cnt_r < OCC_CNT_W'(OCC_DEPTH)) &&
                  (adm_r < ADM_W'(MAX_READER_ADMITS));
  assign adm_wr = !wi_r && (occ_cnt_r == '0) && (rq_cnt_r == '0) && (wq_cnt_r != '0);
  assign adm_rd_last = !((rq_cnt_r > RQ_CNT_W'(1)) &&
                         (occ_cnt_r < OCC_CNT_W'(OCC_DEPTH - 1)) &&
                         (adm_r < ADM_W'(MAX_READER_ADMITS - 1)));

  // A step that emits waits for room in the result register
  assign emit_req = ((state_r == ST_EVENT) && ev_emit) ||
                    ((state_r == ST_ADMIT) && (adm_rd || adm_wr));
  assign out_free = !out_valid_r || !out_stall;
  assign go       = !emit_req || out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FETCH:  if (cmd_valid) state_nxt = ST_EVENT;
      ST_EVENT:  if (go) state_nxt = ST_SETTLE;
      ST_SETTLE: state_nxt = ST_ADMIT;
      ST_ADMIT:  if (go) state_nxt = adm_rd ? ST_ADMIT : ST_FETCH;
      default:   state_nxt = ST_FETCH;
    endcase
  end

  // Actions per state
  always_comb begin
    cmd_pop       = 1'b0;
    rq_push       = 1'b0;
    rq_pop        = 1'b0;
    wq_push       = 1'b0;
    wq_pop        = 1'b0;
    occ_push      = 1'b0;
    occ_pop       = 1'b0;
    occ_push_data = '0;
    wi_set        = 1'b0;
    wi_clr        = 1'b0;
    adm_clr       = 1'b0;
    adm_inc       = 1'b0;
    emit_kind     = KIND_ENTER;
    emit_id       = '0;
    emit_wr       = 1'b0;
    emit_last     = 1'b0;
    unique case (state_r)
      ST_FETCH: begin
        cmd_pop = cmd_valid;
        adm_clr = cmd_valid;
      end
      ST_EVENT: begin
        emit_last = !ev_follow;
        unique case (cmd_r.op)
          OP_READER: begin
            emit_kind = KIND_DROP;
            emit_id   = cmd_r.id;
            rq_push   = go && !rq_full;
          end
          OP_WRITER: begin
            emit_kind = KIND_DROP;
            emit_id   = cmd_r.id;
            emit_wr   = 1'b1;
            wq_push   = go && !wq_full;
          end
          OP_TICK: begin
            emit_kind = KIND_LEAVE;
            emit_id   = occ_rd[ID_W-1:0];
            emit_wr   = occ_rd[OCC_W-1];
            occ_pop   = go && ev_tick;
            wi_clr    = go && ev_tick && occ_rd[OCC_W-1];
          end
          default: begin
          end
        endcase
      end
      ST_SETTLE: begin
      end
      ST_ADMIT: begin
        if (adm_rd) begin
          emit_id       = rq_rd;
          emit_last     = adm_rd_last;
          occ_push_data = {1'b0, rq_rd};
          occ_push      = go;
          rq_pop        = go;
          adm_inc       = go;
        end else if (adm_wr) begin
          emit_id       = wq_rd;
          emit_wr       = 1'b1;
          emit_last     = 1'b1;
          occ_push_data = {1'b1, wq_rd};
          occ_push      = go;
          wq_pop        = go;
          wi_set        = go;
        end
      end
      default: begin
      end
    endcase
  end

  // Head pointers feed the RAM read addresses
  assign rq_head_nxt = !rq_pop ? rq_head_r :
                       (rq_head_r == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0
                                                              : RQ_PTR_W'(rq_head_r + 1'b1);
  assign wq_head_nxt = !wq_pop ? wq_head_r :
                       (wq_head_r == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                              : WQ_PTR_W'(wq_head_r + 1'b1);
  assign occ_head_nxt = !occ_pop ? occ_head_r :
                        (occ_head_r == OCC_PTR_W'(OCC_DEPTH - 1)) ? '0
                                                                  : OCC_PTR_W'(occ_head_r + 1'b1);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      rq_head_r   <= '0;
      rq_tail_r   <= '0;
      rq_cnt_r    <= '0;
      wq_head_r   <= '0;
      wq_tail_r   <= '0;
      wq_cnt_r    <= '0;
      occ_head_r  <= '0;
      occ_tail_r  <= '0;
      occ_cnt_r   <= '0;
      wi_r        <= 1'b0;
      adm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rq_head_r  <= rq_head_nxt;
      wq_head_r  <= wq_head_nxt;
      occ_head_r <= occ_head_nxt;
      // Reader wait queue
      if (rq_push) begin
        rq_tail_r <= (rq_tail_r == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0
                                                            : RQ_PTR_W'(rq_tail_r + 1'b1);
        rq_cnt_r  <= RQ_CNT_W'(rq_cnt_r + 1'b1);
      end else if (rq_pop) begin
        rq_cnt_r  <= RQ_CNT_W'(rq_cnt_r - 1'b1);
      end
      // Writer wait queue
      if (wq_push) begin
        wq_tail_r <= (wq_tail_r == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                            : WQ_PTR_W'(wq_tail_r + 1'b1);
        wq_cnt_r  <= WQ_CNT_W'(wq_cnt_r + 1'b1);
      end else if (wq_pop) begin
        wq_cnt_r  <= WQ_CNT_W'(wq_cnt_r - 1'b1);
      end
      // Occupant queue
      if (occ_push) begin
        occ_tail_r <= (occ_tail_r == OCC_PTR_W'(OCC_DEPTH - 1)) ? '0
                                                                : OCC_PTR_W'(occ_tail_r + 1'b1);
        occ_cnt_r  <= OCC_CNT_W'(occ_cnt_r + 1'b1);
      end else if (occ_pop) begin
        occ_cnt_r  <= OCC_CNT_W'(occ_cnt_r - 1'b1);
      end
      // Writer inside flag
      if (wi_set) begin
        wi_r <= 1'b1;
      end else if (wi_clr) begin
        wi_r <= 1'b0;
      end
      // Readers admitted for the current command
      if (adm_clr) begin
        adm_r <= '0;
      end else if (adm_inc) begin
        adm_r <= ADM_W'(adm_r + 1'b1);
      end
      // Result valid
      if (go && emit_req) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (go && emit_req) begin
      out_kind_r <= emit_kind;
      out_id_r   <= emit_id;
      out_wr_r   <= emit_wr;
      out_last_r <= emit_last;
    end
  end

  // Wait queue and occupant storage
  rwa_ram #(.WIDTH(ID_W), .DEPTH(RQ_DEPTH)) u_rq_ram (
    .clk     (clk),
    .wr_en   (rq_push),
    .wr_addr (rq_tail_r),
    .wr_data (cmd_r.id),
    .rd_addr (rq_head_nxt),
    .rd_data (rq_rd)
  );

  rwa_ram #(.WIDTH(ID_W), .DEPTH(WQ_DEPTH)) u_wq_ram (
    .clk     (clk),
    .wr_en   (wq_push),
    .wr_addr (wq_tail_r),
    .wr_data (cmd_r.id),
    .rd_addr (wq_head_nxt),
    .rd_data (wq_rd)
  );

  rwa_ram #(.WIDTH(OCC_W), .DEPTH(OCC_DEPTH)) u_occ_ram (
    .clk     (clk),
    .wr_en   (occ_push),
    .wr_addr (occ_tail_r),
    .wr_data (occ_push_data),
    .rd_addr (occ_head_nxt),
    .rd_data (occ_rd)
  );

  // Result port
  assign out_valid            = out_valid_r;
  assign out_event_kind       = out_kind_r;
  assign out_person_id        = out_id_r;
  assign out_person_is_writer = out_wr_r;
  assign out_last             = out_last_r;

endmodule

/* hw/rtl/readers_writers_admission_arbiter_core.sv */
// ----------------------------------------------------------------------------
// readers_writers_admission_arbiter_core
// Reader-preference admission arbiter: reader/writer wait queues, occupant
// queue, one result word per entry, departure or dropped arrival.
// ----------------------------------------------------------------------------
// Each input word is a reader arrival, a writer arrival or a tick that lets
// the oldest occupant leave. A two-entry command queue takes input words
// while the back end works, so the input side stalls only when two words
// are already queued. The back end steps through fetch, event, a settle
// state for the wait-queue RAM read, and admission check for each word,
// and repeats the admission check for each reader admitted by that word;
// a step that emits waits while the result side stalls. Results leave one
// per cycle from an output register while out_stall is low; out_last marks
// the final result of each input word, and a word that causes nothing yields no result.
`timescale 1ns / 1ps

module readers_writers_admission_arbiter_core import rwa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_req_type,
  input  logic [ID_W-1:0] in_requester_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_event_kind,
  output logic [ID_W-1:0] out_person_id,
  output logic            out_person_is_writer,
  output logic            out_last
);

  logic     cmd_valid;
  rwa_cmd_t cmd;
  logic     cmd_pop;

  // Front: accept and classify
  rwa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_requester_id (in_requester_id),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  // Back: queues, admissions, results
  rwa_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_kind       (out_event_kind),
    .out_person_id        (out_person_id),
    .out_person_is_writer (out_person_is_writer),
    .out_last             (out_last)
  );

endmodule

/* hw/rtl/rwa_checker.sv */
// ----------------------------------------------------------------------------
// rwa_checker
// Port-level checks on the admission arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "readers_writers_admission_arbiter_core_defines.svh"

module rwa_checker import rwa_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [1:0]      out_event_kind,
  input logic [ID_W-1:0] out_person_id,
  input logic            out_person_is_writer,
  input logic            out_last
);

  // Reset leaves no result pending and the command queue empty
  `RWAAC_CHECK_ALWAYS(a_reset_out_idle, clk, !rst_n |=> !out_valid)
  `RWAAC_CHECK_ALWAYS(a_reset_in_open, clk, !rst_n |=> !in_stall)

  // A stalled result word is held
  `RWAAC_CHECK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `RWAAC_CHECK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_person_id) && $stable(out_event_kind) && $stable(out_last))

  // A writer admission always closes its input word's results
  `RWAAC_CHECK(a_writer_enter_last, clk, rst_n, out_valid && (out_event_kind == KIND_ENTER) && out_person_is_writer |-> out_last)

endmodule

bind readers_writers_admission_arbiter_core rwa_checker u_rwa_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: readers-writers admission arbiter testbench
// Drives reader, writer and tick words into the core and checks every result
// word against an in-bench arbiter model: an opening table of directed words,
// then random traffic, floods that fill the occupant and wait queues, and a
// writer burst that releases the largest admission burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import rwa_pkg::*; ();

  // Request code the core ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int OPENING_ROWS   = 18;

  // One result word
  typedef struct packed {
    rwa_kind_t       kind;
    logic [ID_W-1:0] who;
    logic            is_writer;
    logic            last;
  } outcome_t;

  // How a table row gets its expectation
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } row_check_t;

  typedef struct packed {
    logic [1:0]      rtype;
    logic [ID_W-1:0] rid;
    row_check_t      mode;
    outcome_t        want;
  } stim_row_t;

  localparam outcome_t NO_RESULT = '{KIND_ENTER, 8'h00, 1'b0, 1'b0};

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      in_req_type;
  logic [ID_W-1:0] in_requester_id;
  logic            out_valid;
  logic            out_stall;
  logic [1:0]      out_event_kind;
  logic [ID_W-1:0] out_person_id;
  logic            out_person_is_writer;
  logic            out_last;

  readers_writers_admission_arbiter_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_requester_id      (in_requester_id),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_kind       (out_event_kind),
    .out_person_id        (out_person_id),
    .out_person_is_writer (out_person_is_writer),
    .out_last             (out_last)
  );

  // Arbiter model state
  logic [ID_W-1:0]  waiting_readers[$];
  logic [ID_W-1:0]  waiting_writers[$];
  logic [OCC_W-1:0] occupants[$];
  int unsigned      readers_in;
  bit               writer_in;

  outcome_t    fresh_results[$];
  outcome_t    awaited_results[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          quiet_source;
  bit          hold_request;
  bit          hold_served;

  // Directed opening; typed rows are the ones readable at a glance
  stim_row_t opening [OPENING_ROWS] = '{
    '{REQ_TICK,   8'hC3, CHK_NONE,    NO_RESULT},                        // tick, empty
    '{REQ_READER, 8'h00, CHK_ONE,     '{KIND_ENTER, 8'h00, 1'b0, 1'b1}},
    '{REQ_READER, 8'hFF, CHK_ONE,     '{KIND_ENTER, 8'hFF, 1'b0, 1'b1}},
    '{REQ_WRITER, 8'hAA, CHK_NONE,    NO_RESULT},                        // readers inside
    '{REQ_READER, 8'h55, CHK_ONE,     '{KIND_ENTER, 8'h55, 1'b0, 1'b1}}, // reader pref
    '{REQ_UNUSED, 8'h3C, CHK_NONE,    NO_RESULT},
    '{REQ_TICK,   8'h3C, CHK_ONE,     '{KIND_LEAVE, 8'h00, 1'b0, 1'b1}},
    '{REQ_TICK,   8'hFF, CHK_ONE,     '{KIND_LEAVE, 8'hFF, 1'b0, 1'b1}},
    '{REQ_TICK,   8'h00, CHK_PREDICT, NO_RESULT},                        // leave + writer in
    '{REQ_READER, 8'h11, CHK_NONE,    NO_RESULT},                        // writer inside
    '{REQ_WRITER, 8'h0F, CHK_NONE,    NO_RESULT},
    '{REQ_TICK,   8'hA5, CHK_PREDICT, NO_RESULT},
    '{REQ_TICK,   8'h5A, CHK_PREDICT, NO_RESULT},
    '{REQ_TICK,   8'h81, CHK_ONE,     '{KIND_LEAVE, 8'h0F, 1'b1, 1'b1}},
    '{REQ_WRITER, 8'h80, CHK_ONE,     '{KIND_ENTER, 8'h80, 1'b1, 1'b1}},
    '{REQ_UNUSED, 8'h7E, CHK_NONE,    NO_RESULT},
    '{REQ_TICK,   8'h01, CHK_ONE,     '{KIND_LEAVE, 8'h80, 1'b1, 1'b1}},
    '{REQ_TICK,   8'hFE, CHK_NONE,    NO_RESULT}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one event to the model; results land in fresh_results
  function automatic void arbitrate(input logic [1:0] rtype, input logic [ID_W-1:0] rid);
    logic [OCC_W-1:0] head;
    logic [ID_W-1:0]  pid;
    int unsigned      admits;
    fresh_results.delete();
    admits = 0;
    case (rtype)
      REQ_READER: begin
        if (waiting_readers.size() >= RQ_DEPTH)
          fresh_results.push_back('{KIND_DROP, rid, 1'b0, 1'b0});
        else
          waiting_readers.push_back(rid);
      end
      REQ_WRITER: begin
        if (waiting_writers.size() >= WQ_DEPTH)
          fresh_results.push_back('{KIND_DROP, rid, 1'b1, 1'b0});
        else
          waiting_writers.push_back(rid);
      end
      REQ_TICK: begin
        if (occupants.size() != 0) begin
          head = occupants.pop_front();
          if (head[ID_W])
            writer_in = 1'b0;
          else if (readers_in != 0)
            readers_in--;
          fresh_results.push_back('{KIND_LEAVE, head[ID_W-1:0], head[ID_W], 1'b0});
        end
      end
      default: ;
    endcase
    // readers go in while no writer holds the room
    while (!writer_in && waiting_readers.size() != 0 && occupants.size() < OCC_DEPTH &&
           admits < MAX_READER_ADMITS) begin
      pid = waiting_readers.pop_front();
      readers_in++;
      occupants.push_back({1'b0, pid});
      fresh_results.push_back('{KIND_ENTER, pid, 1'b0, 1'b0});
      admits++;
    end
    // one writer, only into an empty room with no reader waiting
    if (!writer_in && readers_in == 0 && occupants.size() == 0 &&
        waiting_readers.size() == 0 && waiting_writers.size() != 0) begin
      pid = waiting_writers.pop_front();
      writer_in = 1'b1;
      occupants.push_back({1'b1, pid});
      fresh_results.push_back('{KIND_ENTER, pid, 1'b1, 1'b0});
    end
    if (fresh_results.size() != 0)
      fresh_results[fresh_results.size() - 1].last = 1'b1;
  endfunction

  // Offer one input word after a random gap (none while quiet_source is set) and wait for it to be taken
  task automatic offer(input logic [1:0] rtype, input logic [ID_W-1:0] rid);
    int unsigned gap;
    gap = quiet_source ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= rtype;
    in_requester_id <= rid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send a word and queue what it should produce
  task automatic deliver(input logic [1:0] rtype, input logic [ID_W-1:0] rid,
                         input row_check_t mode, input outcome_t want);
    offer(rtype, rid);
    arbitrate(rtype, rid);
    case (mode)
      CHK_PREDICT: foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
      CHK_ONE:     awaited_results.push_back(want);
      default:     ;
    endcase
  endtask

  task automatic send(input logic [1:0] rtype);
    logic [ID_W-1:0] rid;
    rid = ID_W'($urandom_range(0, 255));
    deliver(rtype, rid, CHK_PREDICT, NO_RESULT);
  endtask

  // Random traffic, mostly well-formed arrivals and ticks
  task automatic mixed_run(input int count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      send(REQ_READER);
      else if (roll < 60) send(REQ_WRITER);
      else if (roll < 95) send(REQ_TICK);
      else                send(REQ_UNUSED);
    end
  endtask

  // Tick until the model holds nobody inside or waiting
  task automatic drain();
    while (occupants.size() != 0 || waiting_readers.size() != 0 ||
           waiting_writers.size() != 0)
      send(REQ_TICK);
  endtask

  // Sender pause until every awaited word is back, plus a settling margin
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(input string what, input logic [ID_W-1:0] want,
                                      input logic [ID_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted result word against the oldest expectation
  task automatic take_result();
    outcome_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t ns: unexpected result word, kind %0d id %0d writer %0d last %0d",
               $time, out_event_kind, out_person_id, out_person_is_writer, out_last);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      check_field("event_kind", ID_W'(want.kind), ID_W'(out_event_kind));
      check_field("person_id", want.who, out_person_id);
      check_field("person_is_writer", ID_W'(want.is_writer), ID_W'(out_person_is_writer));
      check_field("last", ID_W'(want.last), ID_W'(out_last));
    end
  endtask

  // Result side: random stall before each word, calm stretches, one long hold
  initial begin : result_sink
    int unsigned hold_off;
    int unsigned calm_left;
    calm_left = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_off = HOLD_CYCLES;
      end else if (calm_left != 0) begin
        calm_left--;
        hold_off = 0;
      end else begin
        if ($urandom_range(0, 7) == 0) calm_left = 30;
        hold_off = $urandom_range(0, 14);
      end
      if (hold_off != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      take_result();
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_READER;
    in_requester_id <= '0;
    quiet_source    = 1'b0;
    hold_request    = 1'b0;
    hold_served     = 1'b0;
    mismatches      = 0;
    readers_in      = 0;
    writer_in       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    for (int r = 0; r < OPENING_ROWS; r++)
      deliver(opening[r].rtype, opening[r].rid, opening[r].mode, opening[r].want);
    settle();

    // random mix
    quiet_source = ($urandom_range(0, 2) == 0);
    mixed_run(20);
    drain();
    settle();

    // reader flood: occupant queue fills, wait queue fills, arrivals drop,
    // while the result side holds off and the input backs up
    quiet_source = 1'b1;
    hold_request = 1'b1;
    repeat (56) send(($urandom_range(0, 19) == 0) ? REQ_TICK : REQ_READER);
    quiet_source = 1'b0;
    drain();
    settle();

    // writer burst: readers queue behind a writer, writer queue overflows,
    // then one tick lets the writer out and the whole reader queue in
    quiet_source = ($urandom_range(0, 1) == 0);
    send(REQ_WRITER);
    repeat (RQ_DEPTH) send(REQ_READER);
    repeat (WQ_DEPTH + 1) send(REQ_WRITER);
    send(REQ_TICK);
    drain();

    // closing mix
    quiet_source = ($urandom_range(0, 2) == 0);
    mixed_run(10);
    settle();

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rwa_pkg.sv
hw/rtl/rwa_ram.sv
hw/rtl/rwa_front.sv
hw/rtl/rwa_back.sv
hw/rtl/readers_writers_admission_arbiter_core.sv
hw/rtl/rwa_checker.sv
dv/tb.sv
